// File: design/htc_pkg.sv
`default_nettype none
package htc_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam logic [7:0]  HUE_LOW_RST  = 8'd0;
    localparam logic [7:0]  HUE_HIGH_RST = 8'd10;
    localparam logic [7:0]  SAT_LOW_RST  = 8'd180;
    localparam logic [7:0]  SAT_HIGH_RST = 8'd255;
    localparam logic [7:0]  VAL_LOW_RST  = 8'd240;
    localparam logic [7:0]  VAL_HIGH_RST = 8'd255;
    localparam logic [10:0] WIDTH_RST    = 11'd640;

    localparam logic [2:0] REG_HUE_LOW  = 3'd0;
    localparam logic [2:0] REG_HUE_HIGH = 3'd1;
    localparam logic [2:0] REG_SAT_LOW  = 3'd2;
    localparam logic [2:0] REG_SAT_HIGH = 3'd3;
    localparam logic [2:0] REG_VAL_LOW  = 3'd4;
    localparam logic [2:0] REG_VAL_HIGH = 3'd5;
    localparam logic [2:0] REG_WIDTH    = 3'd6;

    typedef struct packed {
        logic [7:0]  hue_low;
        logic [7:0]  hue_high;
        logic [7:0]  sat_low;
        logic [7:0]  sat_high;
        logic [7:0]  val_low;
        logic [7:0]  val_high;
        logic [10:0] frame_width;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_pix;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        selected;
        logic        centroid_valid;
        logic [9:0]  centroid_x;
        logic [9:0]  centroid_y;
        logic [20:0] selected_total;
    } t_res;
endpackage
`default_nettype wire

// File: design/htc_if.sv
`default_nettype none
interface htc_pix_if;
    logic            valid;
    logic            ready;
    htc_pkg::t_pix   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface htc_res_if;
    logic            valid;
    logic            ready;
    htc_pkg::t_res   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/hsv_threshold_centroid.sv
// HSV color-window threshold with centroid of selected pixels.
// Input channel pix: one RGB pixel per transfer in raster order, frame_end on
// the last pixel of a frame. Output channel res: one result per pixel, the
// pixel or black, a selected flag, and on the last pixel the centroid.
// The front converts to HSV in a 4-stage pipeline at one pixel per cycle unless stalled.
// The back tracks column/row and sums, one pixel per cycle while the receiver
// is ready; on frame_end it runs two bit-serial dividers with a quotient width
// of 31 by default, and input stalls until the last pixel's result is out.
// The APB port writes the windows and frame_width; write only when idle.
// Reset restores the default windows and clears counters and sums.
// A receiver stall backs up through the output register to the front;
// nothing is dropped.
`default_nettype none
module hsv_threshold_centroid #(
    parameter int MAX_WIDTH  = htc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = htc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    htc_pix_if.sink          pix,
    htc_res_if.source        res
);
    htc_pkg::t_cfg r_cfg;
    htc_pkg::t_pix w_pix;
    logic          w_fv, w_br, w_hit;
    logic [2:0]    w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low     <= htc_pkg::HUE_LOW_RST;
            r_cfg.hue_high    <= htc_pkg::HUE_HIGH_RST;
            r_cfg.sat_low     <= htc_pkg::SAT_LOW_RST;
            r_cfg.sat_high    <= htc_pkg::SAT_HIGH_RST;
            r_cfg.val_low     <= htc_pkg::VAL_LOW_RST;
            r_cfg.val_high    <= htc_pkg::VAL_HIGH_RST;
            r_cfg.frame_width <= htc_pkg::WIDTH_RST;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            case (w_idx)
                htc_pkg::REG_HUE_LOW:  r_cfg.hue_low     <= pwdata[7:0];
                htc_pkg::REG_HUE_HIGH: r_cfg.hue_high    <= pwdata[7:0];
                htc_pkg::REG_SAT_LOW:  r_cfg.sat_low     <= pwdata[7:0];
                htc_pkg::REG_SAT_HIGH: r_cfg.sat_high    <= pwdata[7:0];
                htc_pkg::REG_VAL_LOW:  r_cfg.val_low     <= pwdata[7:0];
                htc_pkg::REG_VAL_HIGH: r_cfg.val_high    <= pwdata[7:0];
                htc_pkg::REG_WIDTH:    r_cfg.frame_width <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            htc_pkg::REG_HUE_LOW:  prdata = {24'd0, r_cfg.hue_low};
            htc_pkg::REG_HUE_HIGH: prdata = {24'd0, r_cfg.hue_high};
            htc_pkg::REG_SAT_LOW:  prdata = {24'd0, r_cfg.sat_low};
            htc_pkg::REG_SAT_HIGH: prdata = {24'd0, r_cfg.sat_high};
            htc_pkg::REG_VAL_LOW:  prdata = {24'd0, r_cfg.val_low};
            htc_pkg::REG_VAL_HIGH: prdata = {24'd0, r_cfg.val_high};
            htc_pkg::REG_WIDTH:    prdata = {21'd0, r_cfg.frame_width};
            default:               prdata = 32'd0;
        endcase
    end

    htc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .pix(pix),
        .o_valid(w_fv), .i_ready(w_br), .o_pix(w_pix), .o_hit(w_hit)
    );

    htc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_fv), .o_ready(w_br), .i_pix(w_pix), .i_hit(w_hit), .res(res)
    );
endmodule
`default_nettype wire

// File: design/htc_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module htc_div #(
    parameter int NW = 30,
    parameter int DW = 21
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_q, n_q;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [DW:0]   w_sh;

    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        n_rem = r_rem;
        n_den = r_den;
        w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
        if (i_start) begin
            n_cnt = CW'(NW);
            n_q   = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CW'(1);
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_q   = {r_q[NW-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
endmodule
`default_nettype wire

// File: design/htc_front.sv
`default_nettype none
// front: HSV conversion and window test, pipelined, one pixel per cycle unless stalled
module htc_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  htc_pkg::t_cfg i_cfg,
    htc_pix_if.sink       pix,
    output logic          o_valid,
    input  wire logic     i_ready,
    output htc_pkg::t_pix o_pix,
    output logic          o_hit
);
    // stage 1: max/min, numerators
    logic          r_v1;
    htc_pkg::t_pix r_p1;
    logic [7:0]    r_mx, r_d;
    logic [10:0]   r_n;
    logic          r_grey;
    // stage 2: products
    logic          r_v2;
    htc_pkg::t_pix r_p2;
    logic [7:0]    r_mx2, r_d2;
    logic [18:0]   r_hn;
    logic [15:0]   r_sn;
    logic          r_grey2;
    // stage 3: upper four quotient bits and partial remainders
    logic          r_v3;
    htc_pkg::t_pix r_p3;
    logic [7:0]    r_mx3, r_d3;
    logic [7:0]    r_h3, r_s3;
    logic [18:0]   r_rh3;
    logic [15:0]   r_rs3;
    logic          r_grey3;
    // stage 4: lower quotient bits and window test
    logic          r_v4;
    htc_pkg::t_pix r_p4;
    logic          r_hit;

    logic          w_adv;
    logic [7:0]    w_r, w_g, w_b, w_mx, w_mn, w_d;
    logic [10:0]   w_n;
    logic [7:0]    w_h1, w_s1;
    logic [18:0]   w_rh1;
    logic [15:0]   w_rs1;
    logic [7:0]    w_h, w_s;

    assign w_adv = !r_v4 || i_ready;
    assign pix.ready = w_adv;

    always_comb begin
        w_r = pix.data.red;
        w_g = pix.data.green;
        w_b = pix.data.blue;
        w_mx = w_r;
        w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_d = w_mx - w_mn;
        if (w_r == w_mx) begin
            w_n = (w_g >= w_b) ? 11'(w_g - w_b)
                               : 11'(11'(6) * 11'(w_d) + 11'(w_g) - 11'(w_b));
        end else if (w_g == w_mx) begin
            w_n = 11'(11'(2) * 11'(w_d) + 11'(w_b) - 11'(w_r));
        end else begin
            w_n = 11'(11'(4) * 11'(w_d) + 11'(w_r) - 11'(w_g));
        end
    end

    // quotients are at most 8 bits: restoring long division, 4 steps per stage
    always_comb begin
        logic [18:0] rh;
        logic [18:0] dh;
        logic [15:0] rs;
        logic [15:0] ds;
        rh = r_hn;
        rs = r_sn;
        w_h1 = '0;
        w_s1 = '0;
        for (int k = 7; k >= 4; k--) begin
            dh = 19'({8'd0, r_d2, 3'd0} - {10'd0, r_d2, 1'b0}) << k;
            ds = 16'({8'd0, r_mx2}) << k;
            if (rh >= dh) begin
                rh = rh - dh;
                w_h1[k] = 1'b1;
            end
            if (rs >= ds) begin
                rs = rs - ds;
                w_s1[k] = 1'b1;
            end
        end
        w_rh1 = rh;
        w_rs1 = rs;
    end

    always_comb begin
        logic [18:0] rh;
        logic [18:0] dh;
        logic [15:0] rs;
        logic [15:0] ds;
        rh = r_rh3;
        rs = r_rs3;
        w_h = r_h3;
        w_s = r_s3;
        for (int k = 3; k >= 0; k--) begin
            dh = 19'({8'd0, r_d3, 3'd0} - {10'd0, r_d3, 1'b0}) << k;
            ds = 16'({8'd0, r_mx3}) << k;
            if (rh >= dh) begin
                rh = rh - dh;
                w_h[k] = 1'b1;
            end
            if (rs >= ds) begin
                rs = rs - ds;
                w_s[k] = 1'b1;
            end
        end
        if (r_grey3) begin
            w_h = '0;
            w_s = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= pix.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (w_adv) begin
            r_p1    <= pix.data;
            r_mx    <= w_mx;
            r_d     <= w_d;
            r_n     <= w_n;
            r_grey  <= (w_d == 8'd0);
            r_p2    <= r_p1;
            r_mx2   <= r_mx;
            r_d2    <= r_d;
            r_hn    <= 19'(r_n) * 19'd255;
            r_sn    <= 16'(r_d) * 16'd255;
            r_grey2 <= r_grey;
            r_p3    <= r_p2;
            r_mx3   <= r_mx2;
            r_d3    <= r_d2;
            r_h3    <= w_h1;
            r_s3    <= w_s1;
            r_rh3   <= w_rh1;
            r_rs3   <= w_rs1;
            r_grey3 <= r_grey2;
            r_p4    <= r_p3;
            r_hit   <= i_cfg.hue_low <= w_h && w_h <= i_cfg.hue_high &&
                       i_cfg.sat_low <= w_s && w_s <= i_cfg.sat_high &&
                       i_cfg.val_low <= r_mx3 && r_mx3 <= i_cfg.val_high;
        end
    end

    assign o_valid = r_v4;
    assign o_pix   = r_p4;
    assign o_hit   = r_hit;
endmodule
`default_nettype wire

// File: design/htc_back.sv
`default_nettype none
// back: coordinate tracking, sums, centroid division on frame end
module htc_back #(
    parameter int MAX_WIDTH  = htc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = htc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  htc_pkg::t_cfg i_cfg,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  htc_pkg::t_pix i_pix,
    input  wire logic     i_hit,
    htc_res_if.source     res
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
    localparam int KW = $clog2(CAP + 1);
    localparam int SXW = XW + KW;
    localparam int SYW = YW + KW;
    localparam int SW = (SXW > SYW) ? SXW : SYW;

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state        r_st, n_st;
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [SXW-1:0] r_sx;
    logic [SYW-1:0] r_sy;
    logic [KW-1:0] r_cnt;
    logic          r_ov;
    htc_pkg::t_res r_res;
    logic          r_start;
    logic          w_acc, w_cnt_ok, w_bx, w_by;
    logic [SW-1:0] w_qx, w_qy;
    logic [11:0]   w_wid;
    logic [SXW-1:0] w_sx;
    logic [SYW-1:0] w_sy;
    logic [KW-1:0] w_cnt;

    assign o_ready  = (r_st == ST_RUN) && (!r_ov || res.ready);
    assign w_acc    = i_valid && o_ready;
    assign w_cnt_ok = i_hit && (32'(r_cnt) < CAP);
    assign w_sx = w_cnt_ok ? r_sx + SXW'(r_col) : r_sx;
    assign w_sy = w_cnt_ok ? r_sy + SYW'(r_row) : r_sy;
    assign w_cnt = w_cnt_ok ? r_cnt + KW'(1) : r_cnt;

    always_comb begin
        w_wid = {1'b0, i_cfg.frame_width};
        if (w_wid == '0) w_wid = 12'd1;
        if (32'(w_wid) > MAX_WIDTH) w_wid = 12'(MAX_WIDTH);
    end

    htc_div #(.NW(SW), .DW(KW)) u_divx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(SW'(r_sx)), .i_den(r_cnt), .o_busy(w_bx), .o_quo(w_qx)
    );
    htc_div #(.NW(SW), .DW(KW)) u_divy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(SW'(r_sy)), .i_den(r_cnt), .o_busy(w_by), .o_quo(w_qy)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_RUN: if (w_acc && i_pix.frame_end) n_st = ST_DIV;
            ST_DIV: if (!r_start && !w_bx && !w_by) n_st = ST_OUT;
            ST_OUT: if (!r_ov || res.ready) n_st = ST_RUN;
            default: n_st = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_RUN;
            r_ov    <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_cnt   <= '0;
            r_start <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_start <= w_acc && i_pix.frame_end;
            if ((w_acc && !i_pix.frame_end) || (r_st == ST_DIV && n_st == ST_OUT)) begin
                r_ov <= 1'b1;
            end else if (res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_acc) begin
                r_res.out_red   <= i_hit ? i_pix.red : 8'd0;
                r_res.out_green <= i_hit ? i_pix.green : 8'd0;
                r_res.out_blue  <= i_hit ? i_pix.blue : 8'd0;
                r_res.selected  <= i_hit;
                r_res.centroid_valid <= i_pix.frame_end;
                r_res.centroid_x <= '0;
                r_res.centroid_y <= '0;
                r_res.selected_total <= '0;
                r_sx  <= w_sx;
                r_sy  <= w_sy;
                r_cnt <= w_cnt;
                if (i_pix.frame_end) begin
                    r_col <= '0;
                    r_row <= '0;
                end else begin
                    if (32'(r_col) + 1 >= 32'(w_wid)) begin
                        r_col <= '0;
                        r_row <= (32'(r_row) + 1 >= MAX_HEIGHT) ? '0 : r_row + YW'(1);
                    end else begin
                        r_col <= r_col + XW'(1);
                    end
                end
            end
            if (r_st == ST_DIV && n_st == ST_OUT) begin
                if (r_cnt != '0) begin
                    r_res.centroid_x <= 10'(w_qx);
                    r_res.centroid_y <= 10'(w_qy);
                end
                r_res.selected_total <= 21'(r_cnt);
                r_sx  <= '0;
                r_sy  <= '0;
                r_cnt <= '0;
            end
        end
    end

    assign res.valid = r_ov;
    assign res.data  = r_res;

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CAP) else $error("hit count over cap");
    a_noacc_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_RUN |-> !o_ready) else $error("accept during divide");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> r_st == ST_DIV) else $error("divider start outside divide");
endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int WDOG_LIMIT = 20000;
    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    htc_pix_if pix ();
    htc_res_if res ();

    hsv_threshold_centroid i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .pix    (pix.sink),
        .res    (res.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    htc_pkg::t_cfg cfg;
    logic [9:0]  col_q;
    logic [9:0]  row_q;
    logic [29:0] sum_col;
    logic [29:0] sum_row;
    logic [20:0] hits;

    htc_pkg::t_res expected_q[$];
    int   err_count;
    int   mismatch_count;
    int   pixels_sent;
    int   frames_sent;
    int   results_seen;
    int   idle_cycles;
    int   stall_mode;

    function automatic void rgb_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, output logic [7:0] h,
                                       output logic [7:0] s, output logic [7:0] v);
        int mx, mn, d, n;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        v = mx[7:0];
        if (mx == 0 || mx == mn) begin
            h = '0;
            s = '0;
            return;
        end
        d = mx - mn;
        s = 8'((255 * d) / mx);
        if (r == mx) n = (g >= b) ? (g - b) : (6 * d + g - b);
        else if (g == mx) n = 2 * d + b - r;
        else n = 4 * d + r - g;
        h = 8'((255 * n) / (6 * d));
    endfunction

    function automatic htc_pkg::t_res predict_pixel(input htc_pkg::t_pix p);
        htc_pkg::t_res o;
        logic [7:0]  h, s, v;
        logic        hit;
        int          w;
        rgb_to_hsv(p.red, p.green, p.blue, h, s, v);
        hit = cfg.hue_low <= h && h <= cfg.hue_high && cfg.sat_low <= s
              && s <= cfg.sat_high && cfg.val_low <= v && v <= cfg.val_high;
        if (hit && hits < 21'(MAX_W * MAX_H)) begin
            sum_col += 30'(col_q);
            sum_row += 30'(row_q);
            hits++;
        end
        o = '0;
        o.out_red   = hit ? p.red : 8'd0;
        o.out_green = hit ? p.green : 8'd0;
        o.out_blue  = hit ? p.blue : 8'd0;
        o.selected  = hit;
        o.centroid_valid = p.frame_end;
        if (p.frame_end) begin
            if (hits != 0) begin
                o.centroid_x = 10'(sum_col / 30'(hits));
                o.centroid_y = 10'(sum_row / 30'(hits));
            end
            o.selected_total = hits;
            sum_col = '0;
            sum_row = '0;
            hits = '0;
            col_q = '0;
            row_q = '0;
            return o;
        end
        w = cfg.frame_width;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (int'(col_q) + 1 >= w) begin
            col_q = '0;
            row_q = (int'(row_q) + 1 >= MAX_H) ? 10'd0 : row_q + 10'd1;
        end else begin
            col_q++;
        end
        return o;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        htc_pkg::t_res want;
        if (i_rst_n && res.valid && res.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %p", res.data);
            end else begin
                want = expected_q.pop_front();
                if (res.data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %p act %p", want, res.data);
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        int c;
        c = $urandom_range(0, 99);
        if (!i_rst_n) res.ready <= 1'b0;
        else case (stall_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= c < 70;
            2: res.ready <= c < 25;
            default: res.ready <= c[0];
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT) begin
            $display("watchdog timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    // valid stays high after a transfer; whoever idles the sender drops it
    task automatic send_pixel(input htc_pkg::t_pix p);
        pix.valid <= 1'b1;
        pix.data  <= p;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        expected_q.push_back(predict_pixel(p));
        pixels_sent++;
        if (p.frame_end) frames_sent++;
    endtask

    int burst_left;

    task automatic send_paced(input htc_pkg::t_pix p);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_pixel(p);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            htc_pkg::REG_HUE_LOW:  cfg.hue_low  = val[7:0];
            htc_pkg::REG_HUE_HIGH: cfg.hue_high = val[7:0];
            htc_pkg::REG_SAT_LOW:  cfg.sat_low  = val[7:0];
            htc_pkg::REG_SAT_HIGH: cfg.sat_high = val[7:0];
            htc_pkg::REG_VAL_LOW:  cfg.val_low  = val[7:0];
            htc_pkg::REG_VAL_HIGH: cfg.val_high = val[7:0];
            htc_pkg::REG_WIDTH:    cfg.frame_width = val[10:0];
            default: ;
        endcase
    endtask

    task automatic set_windows(input int hl, input int hh, input int sl, input int sh,
                               input int vl, input int vh, input int w);
        write_reg(htc_pkg::REG_HUE_LOW, 32'(hl));
        write_reg(htc_pkg::REG_HUE_HIGH, 32'(hh));
        write_reg(htc_pkg::REG_SAT_LOW, 32'(sl));
        write_reg(htc_pkg::REG_SAT_HIGH, 32'(sh));
        write_reg(htc_pkg::REG_VAL_LOW, 32'(vl));
        write_reg(htc_pkg::REG_VAL_HIGH, 32'(vh));
        write_reg(htc_pkg::REG_WIDTH, 32'(w));
    endtask

    function automatic htc_pkg::t_pix mk(input int r, input int g, input int b,
                                         input bit last);
        htc_pkg::t_pix p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        p.frame_end = last;
        return p;
    endfunction

    // pixel biased toward saturated red so frames with a red window have hits
    function automatic htc_pkg::t_pix rand_pixel(input bit last);
        htc_pkg::t_pix p;
        int   k;
        k = $urandom_range(0, 9);
        p = mk($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), last);
        if (k < 3) p = mk(255, $urandom_range(0, 40), $urandom_range(0, 10), last);
        else if (k == 3) p = mk($urandom_range(0, 255) & 8'hf0, 8'h0f, 8'hff, last);
        return p;
    endfunction

    task automatic test_reset_defaults();
        send_pixel(mk(255, 0, 0, 0));
        send_pixel(mk(0, 0, 0, 0));
        send_pixel(mk(255, 10, 0, 0));
        send_pixel(mk(128, 128, 128, 1));
        drain();
    endtask

    task automatic test_directed_hsv();
        set_windows(0, 255, 0, 255, 0, 255, 3);
        send_pixel(mk(0, 0, 0, 0));
        send_pixel(mk(255, 255, 255, 0));
        send_pixel(mk(255, 0, 0, 0));
        send_pixel(mk(0, 255, 0, 0));
        send_pixel(mk(0, 0, 255, 0));
        send_pixel(mk(255, 0, 1, 0));
        send_pixel(mk(255, 255, 0, 0));
        send_pixel(mk(0, 255, 255, 0));
        send_pixel(mk(255, 0, 255, 0));
        send_pixel(mk(1, 0, 0, 0));
        send_pixel(mk(170, 85, 42, 1));
        send_pixel(mk(0, 0, 0, 1));
        drain();
        // inverted window selects nothing; empty frame gives zero centroid
        set_windows(200, 100, 0, 255, 0, 255, 0);
        send_pixel(mk(255, 0, 0, 0));
        send_pixel(mk(0, 255, 0, 1));
        drain();
        set_windows(0, 255, 0, 255, 0, 255, 11'h7ff);
        repeat (5) send_pixel(mk(255, 255, 255, 0));
        send_pixel(mk(9, 9, 9, 1));
        drain();
    endtask

    task automatic test_random_frames(input int n_pix, input int max_len);
        int left;
        left = n_pix;
        while (left > 0) begin
            int len;
            len = $urandom_range(1, max_len);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 3) == 0) stall_mode = $urandom_range(0, 3);
                send_paced(rand_pixel(i == len - 1));
            end
            left -= len;
        end
    endtask

    task automatic test_config_sweep();
        set_windows(0, 12, 150, 255, 200, 255, 5);
        test_random_frames(200, 40);
        drain();
        set_windows($urandom_range(0, 127), $urandom_range(128, 255),
                    $urandom_range(0, 127), $urandom_range(128, 255),
                    $urandom_range(0, 127), $urandom_range(128, 255), 1);
        test_random_frames(150, 25);
        drain();
        set_windows(0, 255, 0, 255, 0, 255, 1024);
        test_random_frames(150, 60);
        drain();
        set_windows(0, 20, 100, 255, 100, 255, 1025);
        test_random_frames(150, 30);
        drain();
        // shrink width below the running column mid-frame
        set_windows(0, 255, 0, 255, 0, 255, 9);
        for (int i = 0; i < 7; i++) send_paced(rand_pixel(0));
        drain();
        write_reg(htc_pkg::REG_WIDTH, 3);
        test_random_frames(150, 20);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 1'b0;
        pix.data = '0;
        res.ready = 1'b0;
        err_count = 0;
        mismatch_count = 0;
        pixels_sent = 0;
        frames_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        stall_mode = 0;
        burst_left = 0;
        cfg = '{htc_pkg::HUE_LOW_RST, htc_pkg::HUE_HIGH_RST, htc_pkg::SAT_LOW_RST,
                htc_pkg::SAT_HIGH_RST, htc_pkg::VAL_LOW_RST, htc_pkg::VAL_HIGH_RST,
                htc_pkg::WIDTH_RST};
        col_q = '0;
        row_q = '0;
        sum_col = '0;
        sum_row = '0;
        hits = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        stall_mode = 1;
        test_directed_hsv();
        test_config_sweep();

        drain();
        err_count = mismatch_count + expected_q.size();
        $display("transfers: %0d pixels in %0d frames, %0d results checked",
                 pixels_sent, frames_sent, results_seen);
        $display("widths 0..2047 incl. wrap/shrink, inverted and full windows, stalls");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
